// File: rtl/fixed_capacity_shift_list_defines.svh
// Assertion macros for the checker file of the shift list.
// Depends on nothing; each user supplies clk and rst in its own scope.
`ifndef FIXED_CAPACITY_SHIFT_LIST_DEFINES_SVH
`define FIXED_CAPACITY_SHIFT_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcsl check failed");

// Next-cycle implication, checked outside reset.
`define FCSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcsl check failed");

`endif

// File: rtl/fcsl_pkg.sv
// Package for the fixed-capacity shift list: sizes, operation codes,
// cell modes and the command and response word types. No dependencies.
package fcsl_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int INDEX_W    = 8;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_POP    = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_GET    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LOWER,
    CELL_TAKE_UPPER
  } cell_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [INDEX_W-1:0]    index;
    logic [WORD_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                  ok;
    logic [WORD_WIDTH-1:0] read_value;
    logic [CNT_W-1:0]      count;
    logic                  full_res;
    logic                  empty_res;
  } rsp_t;

endpackage

// File: rtl/fcsl_cell.sv
// One slot of the shift list: holds a word and can load a new word or take
// the word of either neighbor. Depends on fcsl_pkg.
module fcsl_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  fcsl_pkg::cell_mode_t          mode,
  input  logic [fcsl_pkg::WORD_WIDTH-1:0] value,
  input  logic [fcsl_pkg::WORD_WIDTH-1:0] lower,
  input  logic [fcsl_pkg::WORD_WIDTH-1:0] upper,
  output logic [fcsl_pkg::WORD_WIDTH-1:0] word
);

  logic [fcsl_pkg::WORD_WIDTH-1:0] word_next;

  always_comb begin
    case (mode)
      fcsl_pkg::CELL_LOAD:       word_next = value;
      fcsl_pkg::CELL_TAKE_LOWER: word_next = lower;
      fcsl_pkg::CELL_TAKE_UPPER: word_next = upper;
      default:                   word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else begin
      word <= word_next;
    end
  end

endmodule

// File: rtl/fixed_capacity_shift_list.sv
// Fixed-capacity shift list: a row of fcsl_cell slots plus the command decode.
// Depends on fcsl_pkg and fcsl_cell.
//
// Takes one command word in every cycle (busy is always low) and returns its
// response word in the next cycle, marked by done. All slots update together,
// each taking its neighbor's word for insert or remove, so the rate is one
// command per clock. Done marks each response word for one cycle only; the
// receiver must take it then.
module fixed_capacity_shift_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fcsl_pkg::cmd_t  cmd,
  output logic            done,
  output fcsl_pkg::rsp_t  rsp
);

  localparam int CAP = fcsl_pkg::CAPACITY;
  localparam int WW  = fcsl_pkg::WORD_WIDTH;
  localparam int CW  = fcsl_pkg::CNT_W;
  localparam int IW  = fcsl_pkg::INDEX_W;

  logic                 accept;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        cnt_wide;
  logic                 idx_in_range;
  logic                 push_ok, insert_ok, pop_ok, remove_ok, get_ok;
  logic                 ok_next;
  logic [WW-1:0]        read_next;
  logic [WW-1:0]        words [CAP];
  fcsl_pkg::cell_mode_t modes [CAP];
  fcsl_pkg::rsp_t       rsp_next;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign cnt_wide     = IW'(count);
  assign idx_in_range = cmd.index < IW'(CAP);
  assign push_ok      = (cmd.kind == fcsl_pkg::KIND_PUSH) && (count < CW'(CAP));
  assign insert_ok    = (cmd.kind == fcsl_pkg::KIND_INSERT) && (count < CW'(CAP)) &&
                        idx_in_range && (cmd.index <= cnt_wide);
  assign pop_ok       = (cmd.kind == fcsl_pkg::KIND_POP) && (count != '0);
  assign remove_ok    = (cmd.kind == fcsl_pkg::KIND_REMOVE) && idx_in_range &&
                        (cmd.index < cnt_wide);
  assign get_ok       = (cmd.kind == fcsl_pkg::KIND_GET) && idx_in_range;

  assign ok_next   = push_ok | insert_ok | pop_ok | remove_ok | get_ok;
  assign read_next = get_ok ? words[cmd.index[fcsl_pkg::IDX_W-1:0]] : '0;

  always_comb begin
    count_next = count;
    if (push_ok || insert_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok || remove_ok) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [WW-1:0] lower;
    logic [WW-1:0] upper;

    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = words[i-1];
    end

    if (i == CAP - 1) begin : g_top
      assign upper = words[i];
    end else begin : g_upper
      assign upper = words[i+1];
    end

    always_comb begin
      modes[i] = fcsl_pkg::CELL_HOLD;
      if (accept) begin
        if (push_ok && (count == CW'(i))) begin
          modes[i] = fcsl_pkg::CELL_LOAD;
        end else if (insert_ok && (cmd.index == IW'(i))) begin
          modes[i] = fcsl_pkg::CELL_LOAD;
        end else if (insert_ok && (cmd.index < IW'(i))) begin
          modes[i] = fcsl_pkg::CELL_TAKE_LOWER;
        end else if (remove_ok && (cmd.index <= IW'(i)) && (i < CAP - 1)) begin
          modes[i] = fcsl_pkg::CELL_TAKE_UPPER;
        end
      end
    end

    fcsl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .mode  (modes[i]),
      .value (cmd.value),
      .lower (lower),
      .upper (upper),
      .word  (words[i])
    );
  end

  always_comb begin
    rsp_next.ok         = ok_next;
    rsp_next.read_value = read_next;
    rsp_next.count      = count_next;
    rsp_next.full_res   = count_next == CW'(CAP);
    rsp_next.empty_res  = count_next == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/fcsl_checker.sv
// Port-level checks for the fixed-capacity shift list, bound to its top level.
// Depends on fcsl_pkg and fixed_capacity_shift_list_defines.svh.
`include "fixed_capacity_shift_list_defines.svh"

module fcsl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fcsl_pkg::rsp_t rsp
);

  logic full_want;
  logic empty_want;

  assign full_want  = rsp.count == fcsl_pkg::CNT_W'(fcsl_pkg::CAPACITY);
  assign empty_want = rsp.count == '0;

  `FCSL_ASSERT_NEXT(a_word_answered, start && !busy, done)
  `FCSL_ASSERT_NEXT(a_no_spurious_word, !(start && !busy), !done)
  `FCSL_ASSERT_NOW(a_count_bound, done, rsp.count <= fcsl_pkg::CNT_W'(fcsl_pkg::CAPACITY))
  `FCSL_ASSERT_NOW(a_flags_match, done, (rsp.full_res == full_want) && (rsp.empty_res == empty_want))
  `FCSL_ASSERT_NOW(a_read_zero_on_reject, done && !rsp.ok, rsp.read_value == '0)

endmodule

bind fixed_capacity_shift_list fcsl_checker u_fcsl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for fixed_capacity_shift_list: a directed table, then random
// bursts of commands, each response compared with a table row or a model of the list.
// Depends on fcsl_pkg and the fixed_capacity_shift_list RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;
  localparam logic [fcsl_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [fcsl_pkg::KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [fcsl_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [fcsl_pkg::KIND_W-1:0]     kind;
    logic [fcsl_pkg::INDEX_W-1:0]    index;
    logic [fcsl_pkg::WORD_WIDTH-1:0] value;
    int                              reps;
    bit                              typed;
    fcsl_pkg::rsp_t                  want;
  } plan_row_t;

  localparam fcsl_pkg::rsp_t NO_WANT      = '0;
  localparam fcsl_pkg::rsp_t REJECT_EMPTY = '{1'b0, 32'd0, 5'd0, 1'b0, 1'b1};
  localparam fcsl_pkg::rsp_t REJECT_FULL  = '{1'b0, 32'd0, 5'd16, 1'b1, 1'b0};
  localparam int PLAN_ROWS = 26;

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{fcsl_pkg::KIND_GET,    8'd0,   32'h0,        1,  1'b1, '{1'b1, 32'd0, 5'd0, 1'b0, 1'b1}},
    '{fcsl_pkg::KIND_POP,    8'd0,   32'h0,        1,  1'b1, REJECT_EMPTY},
    '{fcsl_pkg::KIND_REMOVE, 8'd0,   32'h0,        1,  1'b1, REJECT_EMPTY},
    '{fcsl_pkg::KIND_GET,    8'd255, 32'h0,        1,  1'b1, REJECT_EMPTY},
    '{fcsl_pkg::KIND_GET,    8'd16,  32'h0,        1,  1'b1, REJECT_EMPTY},
    '{KIND_UNUSED_LO,        8'd0,   32'h12345678, 1,  1'b1, REJECT_EMPTY},
    '{KIND_UNUSED_HI,        8'd255, 32'hFFFFFFFF, 1,  1'b1, REJECT_EMPTY},
    '{fcsl_pkg::KIND_INSERT, 8'd1,   32'hDEADBEEF, 1,  1'b1, REJECT_EMPTY},
    '{fcsl_pkg::KIND_INSERT, 8'd0,   32'hFFFFFFFF, 1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_PUSH,   8'd0,   32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_INSERT, 8'd1,   32'h55555555, 1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_INSERT, 8'd3,   32'hAAAAAAAA, 1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_PUSH,   8'd0,   32'h00001000, 12, 1'b0, NO_WANT},
    '{fcsl_pkg::KIND_PUSH,   8'd0,   32'h77777777, 1,  1'b1, REJECT_FULL},
    '{fcsl_pkg::KIND_INSERT, 8'd0,   32'h88888888, 1,  1'b1, REJECT_FULL},
    '{fcsl_pkg::KIND_GET,    8'd15,  32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_REMOVE, 8'd16,  32'h0,        1,  1'b1, REJECT_FULL},
    '{fcsl_pkg::KIND_REMOVE, 8'd0,   32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_REMOVE, 8'd15,  32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_GET,    8'd15,  32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_POP,    8'd0,   32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_GET,    8'd14,  32'h0,        1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_INSERT, 8'd15,  32'h0BADF00D, 1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_INSERT, 8'd14,  32'hC0FFEE00, 1,  1'b0, NO_WANT},
    '{fcsl_pkg::KIND_REMOVE, 8'd14,  32'h0,        1,  1'b0, NO_WANT},
    '{KIND_UNUSED_MID,       8'd3,   32'h0,        1,  1'b0, NO_WANT}
  };

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fcsl_pkg::cmd_t cmd;
  logic done;
  fcsl_pkg::rsp_t rsp;

  logic [fcsl_pkg::WORD_WIDTH-1:0] list_slots [fcsl_pkg::CAPACITY];
  int list_count;
  fcsl_pkg::rsp_t pending_rsps [$];

  int words_sent;
  int rsps_checked;
  int mismatches;
  int rejects_seen;
  int fulls_seen;
  int empties_seen;
  int cycles;

  fixed_capacity_shift_list dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic fcsl_pkg::rsp_t predict_list_op(input fcsl_pkg::cmd_t c);
    fcsl_pkg::rsp_t r;
    int i;
    int idx;
    r = '0;
    idx = c.index;
    case (c.kind)
      fcsl_pkg::KIND_PUSH: begin
        if (list_count < fcsl_pkg::CAPACITY) begin
          list_slots[list_count] = c.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      fcsl_pkg::KIND_INSERT: begin
        if (list_count < fcsl_pkg::CAPACITY && idx < fcsl_pkg::CAPACITY &&
            idx <= list_count) begin
          for (i = fcsl_pkg::CAPACITY - 1; i > idx; i--) list_slots[i] = list_slots[i-1];
          list_slots[idx] = c.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      fcsl_pkg::KIND_POP: begin
        if (list_count > 0) begin
          list_count--;
          r.ok = 1'b1;
        end
      end
      fcsl_pkg::KIND_REMOVE: begin
        if (idx < fcsl_pkg::CAPACITY && idx < list_count) begin
          for (i = idx; i < fcsl_pkg::CAPACITY - 1; i++) list_slots[i] = list_slots[i+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      fcsl_pkg::KIND_GET: begin
        if (idx < fcsl_pkg::CAPACITY) begin
          r.read_value = list_slots[idx];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = fcsl_pkg::CNT_W'(list_count);
    r.full_res = (list_count == fcsl_pkg::CAPACITY);
    r.empty_res = (list_count == 0);
    return r;
  endfunction

  // Called just after a falling edge; returns just after the next falling edge.
  task automatic send_word(input fcsl_pkg::cmd_t c, input bit typed,
                           input fcsl_pkg::rsp_t want);
    fcsl_pkg::rsp_t predicted;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predicted = predict_list_op(c);
    pending_rsps.push_back(typed ? want : predicted);
    words_sent++;
    if (!predicted.ok) rejects_seen++;
    if (predicted.full_res) fulls_seen++;
    if (predicted.empty_res) empties_seen++;
    @(negedge clk);
  endtask

  task automatic drain_pause();
    start <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    fcsl_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: response with nothing expected: ok=%0b rd=%h cnt=%0d %s=%0b %s=%0b",
                   rsp.ok, rsp.read_value, rsp.count, "full", rsp.full_res,
                   "empty", rsp.empty_res);
      end else begin
        want = pending_rsps.pop_front();
        rsps_checked++;
        if (rsp.ok !== want.ok || rsp.read_value !== want.read_value ||
            rsp.count !== want.count || rsp.full_res !== want.full_res ||
            rsp.empty_res !== want.empty_res) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("ERROR: response %0d expected ok=%0b rd=%h cnt=%0d full=%0b empty=%0b,",
                     rsps_checked, want.ok, want.read_value, want.count, want.full_res,
                     want.empty_res);
            $display("       got ok=%0b rd=%h cnt=%0d full=%0b empty=%0b",
                     rsp.ok, rsp.read_value, rsp.count, rsp.full_res, rsp.empty_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fixed_capacity_shift_list");
      $finish;
    end
  end

  initial begin
    fcsl_pkg::cmd_t c;
    int row;
    int r;
    int items_left;
    int burst_len;
    int gap;
    int pick;
    bit growing;
    bit paused;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    words_sent = 0;
    rsps_checked = 0;
    mismatches = 0;
    rejects_seen = 0;
    fulls_seen = 0;
    empties_seen = 0;
    cycles = 0;
    list_count = 0;
    for (int i = 0; i < fcsl_pkg::CAPACITY; i++) list_slots[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      for (r = 0; r < DIRECTED_PLAN[row].reps; r++) begin
        c.kind = DIRECTED_PLAN[row].kind;
        c.index = DIRECTED_PLAN[row].index;
        c.value = DIRECTED_PLAN[row].value + fcsl_pkg::WORD_WIDTH'(r);
        send_word(c, DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].want);
      end
    end
    drain_pause();

    items_left = RANDOM_WORDS;
    growing = 1'b1;
    paused = 1'b0;
    while (items_left > 0) begin
      burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 24);
      for (int b = 0; b < burst_len && items_left > 0; b++) begin
        if (list_count == fcsl_pkg::CAPACITY) growing = 1'b0;
        else if (list_count == 0) growing = 1'b1;
        else if ($urandom_range(0, 49) == 0) growing = ~growing;
        pick = $urandom_range(0, 99);
        if (pick < 4)
          c.kind = fcsl_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        else if (pick < (growing ? 34 : 14)) c.kind = fcsl_pkg::KIND_PUSH;
        else if (pick < (growing ? 64 : 24)) c.kind = fcsl_pkg::KIND_INSERT;
        else if (pick < (growing ? 72 : 52)) c.kind = fcsl_pkg::KIND_POP;
        else if (pick < 80) c.kind = fcsl_pkg::KIND_REMOVE;
        else c.kind = fcsl_pkg::KIND_GET;
        if ($urandom_range(0, 99) < 15)
          c.index = fcsl_pkg::INDEX_W'($urandom_range(0, 255));
        else if (c.kind == fcsl_pkg::KIND_INSERT)
          c.index = fcsl_pkg::INDEX_W'($urandom_range(0, list_count + 1));
        else if (c.kind == fcsl_pkg::KIND_REMOVE)
          c.index = (list_count > 0) ? fcsl_pkg::INDEX_W'($urandom_range(0, list_count - 1))
                                     : '0;
        else c.index = fcsl_pkg::INDEX_W'($urandom_range(0, fcsl_pkg::CAPACITY - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) c.value = '0;
        else if (pick < 10) c.value = '1;
        else c.value = fcsl_pkg::WORD_WIDTH'($urandom);
        send_word(c, 1'b0, NO_WANT);
        items_left--;
        if (!paused && items_left == RANDOM_WORDS / 2) begin
          paused = 1'b1;
          drain_pause();
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        cmd <= fcsl_pkg::cmd_t'($bits(fcsl_pkg::cmd_t)'({$urandom, $urandom}));
        repeat (gap) @(negedge clk);
      end
    end

    start <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d command words (%0d rejected) and checked %0d responses.",
             words_sent, rejects_seen, rsps_checked);
    $display("The list was full after %0d words and empty after %0d; %0d mismatches.",
             fulls_seen, empties_seen, mismatches);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("PASS fixed_capacity_shift_list");
    end else begin
      $display("FAIL fixed_capacity_shift_list");
    end
    $finish;
  end

endmodule
